[hw/rtl/wrfm_pkg.sv]
// ----------------------------------------------------------------------------
// wrfm_pkg
// Shared types and codes of the warp register file with masked writes.
// ----------------------------------------------------------------------------
package wrfm_pkg;

    // operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register file selector codes (code 3 behaves as none)
    localparam logic [1:0] RF_NONE  = 2'd0;
    localparam logic [1:0] RF_INT   = 2'd1;
    localparam logic [1:0] RF_FLOAT = 2'd2;

    // lanes carried on the ports and width of the float file
    localparam int LANES_IO = 4;
    localparam int FLT_W    = 64;

    // what the output stage needs to know about the item in flight
    typedef struct packed {
        logic rd_int;   // integer read, take integer memory data
        logic rd_flt;   // float read, take float memory data
        logic err;      // warp slot out of range
    } wrfm_meta_t;

endpackage

[hw/rtl/wrfm_ram.sv]
// ----------------------------------------------------------------------------
// wrfm_ram
// Synchronous single-port-per-direction RAM with byte write enables and a
// registered read port.
// ----------------------------------------------------------------------------
module wrfm_ram #(
    parameter int DATA_W = 128,
    parameter int DEPTH  = 128,
    parameter int AW     = 7
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_W-1:0]     wdata,
    input  logic [DATA_W/8-1:0]   wbe,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_W-1:0]     rdata
);
    localparam int NB = DATA_W / 8;

    logic [DATA_W-1:0] mem [DEPTH];

    // byte-masked write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < NB; b++)
            begin
                if (wbe[b])
                begin
                    mem[waddr][b*8 +: 8] <= wdata[b*8 +: 8];
                end
            end
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/wrfm_init.sv]
// ----------------------------------------------------------------------------
// wrfm_init
// Post-reset clearing sequencer: walks every memory row once, one per cycle.
// ----------------------------------------------------------------------------
module wrfm_init #(
    parameter int ROWS = 128,
    parameter int AW   = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    output logic          active,
    output logic [AW-1:0] addr
);
    localparam logic [AW-1:0] LAST = AW'(ROWS - 1);

    logic          active_reg;
    logic [AW-1:0] cnt_reg;

    // row counter, stops after the last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == LAST)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign active = active_reg;
    assign addr   = cnt_reg;

endmodule

[hw/rtl/wrfm_out.sv]
// ----------------------------------------------------------------------------
// wrfm_out
// Result stage: picks lane values from the memory read data and holds the
// result item until the receiver takes it.
// ----------------------------------------------------------------------------
module wrfm_out #(
    parameter int THREADS = 4,
    parameter int XLEN    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    input  wrfm_pkg::wrfm_meta_t              s1_meta,
    input  logic [THREADS*XLEN-1:0]           int_rdata,
    input  logic [THREADS*wrfm_pkg::FLT_W-1:0] flt_rdata,
    output logic                              s1_take,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [63:0]                       lane0_value,
    output logic [63:0]                       lane1_value,
    output logic [63:0]                       lane2_value,
    output logic [63:0]                       lane3_value,
    output logic                              slot_error
);
    import wrfm_pkg::*;

    logic        valid_reg;
    logic [63:0] value_reg [LANES_IO];
    logic [63:0] value_next [LANES_IO];
    logic        err_reg;

    // stage 1 moves on when the output register is free or being taken
    assign s1_take = s1_valid && (!valid_reg || !out_stall);

    // lane value select, zero-extend integers
    always_comb
    begin
        for (int t = 0; t < LANES_IO; t++)
        begin
            value_next[t] = '0;
        end
        for (int t = 0; t < THREADS; t++)
        begin
            if (s1_meta.rd_int)
            begin
                value_next[t] = 64'(int_rdata[t*XLEN +: XLEN]);
            end
            else if (s1_meta.rd_flt)
            begin
                value_next[t] = flt_rdata[t*FLT_W +: FLT_W];
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            value_reg <= value_next;
            err_reg   <= s1_meta.err;
        end
    end

    assign out_valid   = valid_reg;
    assign lane0_value = value_reg[0];
    assign lane1_value = value_reg[1];
    assign lane2_value = value_reg[2];
    assign lane3_value = value_reg[3];
    assign slot_error  = err_reg;

endmodule

[hw/rtl/warp_register_file_masked_write_top.sv]
// ----------------------------------------------------------------------------
// warp_register_file_masked_write_top
// Per-warp-slot SIMT register file (integer and float files) with lane and
// byte masked writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one access item: a read of one
//   register for all lanes or a lane- and byte-masked write. Output channel
//   (out_valid/out_stall) returns exactly one result item per access: lane
//   values for reads, zeros for writes, slot_error for an out-of-range slot.
//   Path: an accepted item passes the memory read register, then the output
//   register, which raises out_valid.
//   Throughput: one item per cycle while neither clearing nor a receiver
//   stall holds the input; each access uses the memory port once, and byte
//   enables merge a masked write into the row.
//   Reset: both files are cleared by a pass over all WARP_SLOTS*REGS rows,
//   one row per cycle (128 rows by default); in_stall is high meanwhile.
//   Receiver stall: the result register holds, one more item waits in the
//   read stage, then in_stall rises until the receiver takes the result.
// ----------------------------------------------------------------------------
module warp_register_file_masked_write_top #(
    parameter int WARP_SLOTS      = 4,
    parameter int THREADS         = 4,
    parameter int REGS            = 32,
    parameter int XLEN            = 32,
    parameter int ISSUE_LANES     = 1,
    parameter int COLLECTOR_UNITS = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [3:0]  warp_id,
    input  logic [1:0]  reg_file,
    input  logic [4:0]  reg_index,
    input  logic [3:0]  lane_enable,
    input  logic [7:0]  byte_select,
    input  logic [63:0] lane0_data,
    input  logic [63:0] lane1_data,
    input  logic [63:0] lane2_data,
    input  logic [63:0] lane3_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] lane0_value,
    output logic [63:0] lane1_value,
    output logic [63:0] lane2_value,
    output logic [63:0] lane3_value,
    output logic        slot_error
);
    import wrfm_pkg::*;

    localparam int ROWS     = WARP_SLOTS * REGS;
    localparam int AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_DIV = ISSUE_LANES * COLLECTOR_UNITS;
    localparam int XB       = XLEN / 8;
    localparam int FB       = FLT_W / 8;
    localparam int INT_W    = THREADS * XLEN;
    localparam int FROW_W   = THREADS * FLT_W;

    logic [63:0]         lane_data [LANES_IO];
    logic [4:0]          slot_idx;
    logic                err;
    logic                ok;
    logic                accept;
    logic [AW-1:0]       item_addr;
    logic                clearing;
    logic [AW-1:0]       clear_addr;
    logic [AW-1:0]       waddr;
    logic                int_we_item;
    logic                flt_we_item;
    logic                int_we;
    logic                flt_we;
    logic [INT_W-1:0]    int_wdata;
    logic [INT_W/8-1:0]  int_wbe;
    logic [FROW_W-1:0]   flt_wdata;
    logic [FROW_W/8-1:0] flt_wbe;
    logic [INT_W-1:0]    int_rdata;
    logic [FROW_W-1:0]   flt_rdata;
    logic                s1_valid_reg;
    wrfm_meta_t          s1_meta_reg;
    wrfm_meta_t          meta_next;
    logic                s1_take;

    assign lane_data[0] = lane0_data;
    assign lane_data[1] = lane1_data;
    assign lane_data[2] = lane2_data;
    assign lane_data[3] = lane3_data;

    // warp slot: constant lookup over every warp number
    always_comb
    begin
        slot_idx = '0;
        for (int w = 0; w < 16; w++)
        begin
            if (warp_id == 4'(w))
            begin
                slot_idx = 5'(w / SLOT_DIV);
            end
        end
    end

    // slot check and row address
    assign err       = slot_idx >= 5'(WARP_SLOTS);
    assign ok        = !err && ({1'b0, reg_index} < 6'(REGS))
                       && (reg_file == RF_INT || reg_file == RF_FLOAT);
    assign item_addr = ok ? AW'(slot_idx * REGS + reg_index) : '0;

    // input handshake
    assign in_stall = clearing || (s1_valid_reg && !s1_take);
    assign accept   = in_valid && !in_stall;

    // write enables
    assign int_we_item = accept && ok && operation == OP_WRITE && reg_file == RF_INT;
    assign flt_we_item = accept && ok && operation == OP_WRITE && reg_file == RF_FLOAT;
    assign int_we      = clearing || int_we_item;
    assign flt_we      = clearing || flt_we_item;
    assign waddr       = clearing ? clear_addr : item_addr;

    // write data and byte enables; clearing writes zeros to whole rows
    always_comb
    begin
        int_wdata = '0;
        int_wbe   = '0;
        flt_wdata = '0;
        flt_wbe   = '0;
        for (int t = 0; t < THREADS; t++)
        begin
            if (!clearing)
            begin
                int_wdata[t*XLEN +: XLEN]   = lane_data[t][XLEN-1:0];
                flt_wdata[t*FLT_W +: FLT_W] = lane_data[t];
            end
            for (int b = 0; b < XB; b++)
            begin
                int_wbe[t*XB + b] = clearing || (lane_enable[t] && byte_select[b]);
            end
            for (int b = 0; b < FB; b++)
            begin
                flt_wbe[t*FB + b] = clearing || (lane_enable[t] && byte_select[b]);
            end
        end
    end

    // clearing pass after reset
    wrfm_init #(
        .ROWS (ROWS),
        .AW   (AW)
    ) u_init (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (clearing),
        .addr   (clear_addr)
    );

    // integer file
    wrfm_ram #(
        .DATA_W (INT_W),
        .DEPTH  (ROWS),
        .AW     (AW)
    ) u_int_ram (
        .clk   (clk),
        .we    (int_we),
        .waddr (waddr),
        .wdata (int_wdata),
        .wbe   (int_wbe),
        .re    (accept),
        .raddr (item_addr),
        .rdata (int_rdata)
    );

    // float file
    wrfm_ram #(
        .DATA_W (FROW_W),
        .DEPTH  (ROWS),
        .AW     (AW)
    ) u_flt_ram (
        .clk   (clk),
        .we    (flt_we),
        .waddr (waddr),
        .wdata (flt_wdata),
        .wbe   (flt_wbe),
        .re    (accept),
        .raddr (item_addr),
        .rdata (flt_rdata)
    );

    // read stage bookkeeping
    assign meta_next.rd_int = ok && operation == OP_READ && reg_file == RF_INT;
    assign meta_next.rd_flt = ok && operation == OP_READ && reg_file == RF_FLOAT;
    assign meta_next.err    = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_next;
        end
    end

    // result stage
    wrfm_out #(
        .THREADS (THREADS),
        .XLEN    (XLEN)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid_reg),
        .s1_meta     (s1_meta_reg),
        .int_rdata   (int_rdata),
        .flt_rdata   (flt_rdata),
        .s1_take     (s1_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lane0_value (lane0_value),
        .lane1_value (lane1_value),
        .lane2_value (lane2_value),
        .lane3_value (lane3_value),
        .slot_error  (slot_error)
    );

    // no item write may collide with the clearing pass
    a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (int_we_item || flt_we_item) |-> !clearing)
        else $error("item write during clearing pass");

    // clearing ends right after the last row
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (clearing && clear_addr == AW'(ROWS - 1)) |=> !clearing)
        else $error("clearing pass overran");

    // an out-of-range slot never returns data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && slot_error) |-> (lane0_value == '0 && lane1_value == '0
            && lane2_value == '0 && lane3_value == '0))
        else $error("slot error with nonzero lane value");

    // input backpressure only from clearing or a stalled receiver
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (clearing || out_stall))
        else $error("input stalled without cause");

    // a read item never carries the slot error
    a_meta_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_meta_reg.err && (s1_meta_reg.rd_int || s1_meta_reg.rd_flt)))
        else $error("read flagged with slot error");

endmodule

[bench/tb_warp_register_file_masked_write_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_warp_register_file_masked_write_top
// Self-checking bench for the warp register file with lane and byte masked
// writes. A queue of access items (directed corner cases, then random mixes
// aimed at a few hot registers) feeds a clocked driver; a clocked monitor
// compares every result against a predictor that keeps its own copy of both
// register files. Both channels idle and stall at random, with a calm window.
// ----------------------------------------------------------------------------
module tb_warp_register_file_masked_write_top;

    import wrfm_pkg::*;

    // block configuration (matches the instance below)
    localparam int SLOT_COUNT = 4;
    localparam int LANE_COUNT = 4;
    localparam int REG_COUNT  = 32;
    localparam int INT_W      = 32;
    localparam int ISSUE_W    = 1;
    localparam int OPC_COUNT  = 1;

    // unused selector code, handled like none
    localparam logic [1:0] RF_UNUSED = 2'd3;

    // stretch of items with no idling on either side
    localparam int CALM_FIRST = 400;
    localparam int CALM_LAST  = 700;
    localparam int RANDOM_ITEMS = 1150;

    typedef struct packed {
        logic                           operation;
        logic [3:0]                     warp_id;
        logic [1:0]                     reg_file;
        logic [4:0]                     reg_index;
        logic [3:0]                     lane_enable;
        logic [7:0]                     byte_select;
        logic [LANES_IO-1:0][63:0]      data;
    } access_t;

    typedef struct packed {
        logic [LANES_IO-1:0][63:0]      value;
        logic                           err;
    } readout_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_READ;
    logic [3:0]  warp_id = '0;
    logic [1:0]  reg_file = RF_NONE;
    logic [4:0]  reg_index = '0;
    logic [3:0]  lane_enable = '0;
    logic [7:0]  byte_select = '0;
    logic [63:0] lane0_data = '0;
    logic [63:0] lane1_data = '0;
    logic [63:0] lane2_data = '0;
    logic [63:0] lane3_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] lane0_value;
    logic [63:0] lane1_value;
    logic [63:0] lane2_value;
    logic [63:0] lane3_value;
    logic        slot_error;

    // predictor copy of both files
    logic [INT_W-1:0] int_regs [SLOT_COUNT][REG_COUNT][LANE_COUNT];
    logic [63:0]      flt_regs [SLOT_COUNT][REG_COUNT][LANE_COUNT];

    access_t  pending_access [$];
    readout_t expected_readout [$];
    access_t  access_on_bus;
    logic     access_taken = 1'b0;
    int       issued_count = 0;
    int       fail_count = 0;
    wire      calm = (issued_count >= CALM_FIRST) && (issued_count < CALM_LAST);

    warp_register_file_masked_write_top #(
        .WARP_SLOTS      (SLOT_COUNT),
        .THREADS         (LANE_COUNT),
        .REGS            (REG_COUNT),
        .XLEN            (INT_W),
        .ISSUE_LANES     (ISSUE_W),
        .COLLECTOR_UNITS (OPC_COUNT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .warp_id     (warp_id),
        .reg_file    (reg_file),
        .reg_index   (reg_index),
        .lane_enable (lane_enable),
        .byte_select (byte_select),
        .lane0_data  (lane0_data),
        .lane1_data  (lane1_data),
        .lane2_data  (lane2_data),
        .lane3_data  (lane3_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lane0_value (lane0_value),
        .lane1_value (lane1_value),
        .lane2_value (lane2_value),
        .lane3_value (lane3_value),
        .slot_error  (slot_error)
    );

    // apply one access to the file copy and return its readout
    function automatic readout_t predict_access(input access_t a);
        readout_t r;
        int slot;
        logic [63:0] mask;
        r = '0;
        slot = (int'(a.warp_id) / ISSUE_W) / OPC_COUNT;
        if (slot >= SLOT_COUNT)
        begin
            r.err = 1'b1;
            return r;
        end
        if (!(a.reg_file == RF_INT || a.reg_file == RF_FLOAT) || a.reg_index >= REG_COUNT)
            return r;
        mask = '0;
        for (int b = 0; b < 8; b++)
            if (a.byte_select[b])
                mask[8*b +: 8] = 8'hFF;
        for (int t = 0; t < LANE_COUNT; t++)
        begin
            if (a.reg_file == RF_INT)
            begin
                if (a.operation == OP_READ)
                    r.value[t] = 64'(int_regs[slot][a.reg_index][t]);
                else if (a.lane_enable[t])
                    int_regs[slot][a.reg_index][t] =
                        (int_regs[slot][a.reg_index][t] & ~mask[INT_W-1:0]) |
                        (a.data[t][INT_W-1:0] & mask[INT_W-1:0]);
            end
            else
            begin
                if (a.operation == OP_READ)
                    r.value[t] = flt_regs[slot][a.reg_index][t];
                else if (a.lane_enable[t])
                    flt_regs[slot][a.reg_index][t] =
                        (flt_regs[slot][a.reg_index][t] & ~mask) | (a.data[t] & mask);
            end
        end
        return r;
    endfunction

    function automatic access_t make_access(input logic op, input logic [3:0] wid,
                                            input logic [1:0] rf, input logic [4:0] ri,
                                            input logic [3:0] en, input logic [7:0] sel,
                                            input logic [LANES_IO-1:0][63:0] d);
        access_t a;
        a.operation   = op;
        a.warp_id     = wid;
        a.reg_file    = rf;
        a.reg_index   = ri;
        a.lane_enable = en;
        a.byte_select = sel;
        a.data        = d;
        return a;
    endfunction

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // driver: holds an item until taken, idles at random otherwise
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || access_taken))
        begin
            if (pending_access.size() != 0 && (calm || $urandom_range(0, 99) >= 11))
            begin
                access_on_bus = pending_access.pop_front();
                operation   <= access_on_bus.operation;
                warp_id     <= access_on_bus.warp_id;
                reg_file    <= access_on_bus.reg_file;
                reg_index   <= access_on_bus.reg_index;
                lane_enable <= access_on_bus.lane_enable;
                byte_select <= access_on_bus.byte_select;
                lane0_data  <= access_on_bus.data[0];
                lane1_data  <= access_on_bus.data[1];
                lane2_data  <= access_on_bus.data[2];
                lane3_data  <= access_on_bus.data[3];
                in_valid    <= 1'b1;
                issued_count <= issued_count + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        readout_t want;
        logic [LANES_IO-1:0][63:0] got;
        access_taken = in_valid && !in_stall;
        if (access_taken)
            expected_readout.push_back(predict_access(access_on_bus));
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got = {lane3_value, lane2_value, lane1_value, lane0_value};
            if (expected_readout.size() == 0)
            begin
                $error("result with nothing expected: slot_error %b", slot_error);
                fail_count++;
            end
            else
            begin
                want = expected_readout.pop_front();
                for (int t = 0; t < LANES_IO; t++)
                    if (got[t] !== want.value[t])
                    begin
                        $error("lane%0d_value expected %h got %h", t, want.value[t], got[t]);
                        fail_count++;
                    end
                if (slot_error !== want.err)
                begin
                    $error("slot_error expected %b got %b", want.err, slot_error);
                    fail_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [LANES_IO-1:0][63:0] d;
        logic [4:0] hot_regs [4];
        logic [3:0] wid;
        logic [1:0] rf;
        logic [4:0] ri;
        logic [7:0] sel;
        int r;

        hot_regs = '{5'd0, 5'd1, 5'd30, 5'd31};
        for (int s = 0; s < SLOT_COUNT; s++)
            for (int g = 0; g < REG_COUNT; g++)
                for (int t = 0; t < LANE_COUNT; t++)
                begin
                    int_regs[s][g][t] = '0;
                    flt_regs[s][g][t] = '0;
                end

        // directed: reset contents, full and partial masks, errors, unused types
        d = '0;
        pending_access.push_back(make_access(OP_READ,  4'd0,  RF_INT,   5'd0,  4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd3,  RF_FLOAT, 5'd31, 4'hF, 8'hFF, d));
        d = '1;
        pending_access.push_back(make_access(OP_WRITE, 4'd0,  RF_INT,   5'd0,  4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd0,  RF_INT,   5'd0,  4'h0, 8'h00, d));
        pending_access.push_back(make_access(OP_WRITE, 4'd3,  RF_FLOAT, 5'd31, 4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd3,  RF_FLOAT, 5'd31, 4'h0, 8'h00, d));
        d = '0;
        // upper byte lanes fall outside the integer width
        pending_access.push_back(make_access(OP_WRITE, 4'd0,  RF_INT,   5'd0,  4'h5, 8'hF0, d));
        pending_access.push_back(make_access(OP_WRITE, 4'd0,  RF_INT,   5'd0,  4'hA, 8'h05, d));
        pending_access.push_back(make_access(OP_READ,  4'd0,  RF_INT,   5'd0,  4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_WRITE, 4'd3,  RF_FLOAT, 5'd31, 4'h0, 8'hFF, d));
        pending_access.push_back(make_access(OP_WRITE, 4'd3,  RF_FLOAT, 5'd31, 4'h1, 8'h80, d));
        pending_access.push_back(make_access(OP_READ,  4'd3,  RF_FLOAT, 5'd31, 4'hF, 8'hFF, d));
        // out-of-range warp slots
        pending_access.push_back(make_access(OP_WRITE, 4'd15, RF_INT,   5'd0,  4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd4,  RF_FLOAT, 5'd31, 4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd15, RF_INT,   5'd0,  4'hF, 8'hFF, d));
        // no file selected, and the unused selector
        pending_access.push_back(make_access(OP_WRITE, 4'd0,  RF_NONE,   5'd0, 4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_WRITE, 4'd0,  RF_UNUSED, 5'd0, 4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd0,  RF_NONE,   5'd0, 4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd0,  RF_UNUSED, 5'd0, 4'hF, 8'hFF, d));
        pending_access.push_back(make_access(OP_READ,  4'd0,  RF_INT,    5'd0, 4'hF, 8'hFF, d));
        // distinct lane data, middle bytes only; the integer file stays apart
        d = {64'hF0E1D2C3B4A59687, 64'h0123456789ABCDEF,
             64'hDEADBEEFCAFEF00D, 64'h5A5AA5A5C3C33C3C};
        pending_access.push_back(make_access(OP_WRITE, 4'd1,  RF_FLOAT, 5'd5,  4'hF, 8'h3C, d));
        pending_access.push_back(make_access(OP_READ,  4'd1,  RF_FLOAT, 5'd5,  4'h0, 8'h00, d));
        pending_access.push_back(make_access(OP_READ,  4'd1,  RF_INT,   5'd5,  4'h0, 8'h00, d));

        // random: mostly valid slots and real files, hot registers for read-after-write
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            wid = ($urandom_range(0, 99) < 75) ? 4'($urandom_range(0, SLOT_COUNT - 1))
                                               : 4'($urandom_range(0, 15));
            r = $urandom_range(0, 99);
            rf = (r < 45) ? RF_INT : (r < 88) ? RF_FLOAT : (r < 95) ? RF_NONE : RF_UNUSED;
            ri = ($urandom_range(0, 99) < 60) ? hot_regs[$urandom_range(0, 3)]
                                              : 5'($urandom_range(0, 31));
            sel = ($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
            for (int t = 0; t < LANES_IO; t++)
            begin
                r = $urandom_range(0, 9);
                d[t] = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
            end
            pending_access.push_back(make_access(1'($urandom_range(0, 1)), wid, rf, ri,
                                                 4'($urandom_range(0, 15)), sel, d));
        end

        // reset, then let the queue drain
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_access.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_readout.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
